[design/mdrdr_pkg.sv]
// shared constants and types for the dirty-row display refresh block
`timescale 1ns / 1ps
`default_nettype none

package mdrdr_pkg;

    localparam int DEF_MAX_ROW_BYTES = 32;
    localparam int DEF_MAX_ROWS      = 64;
    localparam int QUEUE_DEPTH       = 2;
    localparam int CFG_IDX_W         = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = CFG_IDX_W'(1);

    localparam logic [7:0] CMD_COLUMN   = 8'h15;
    localparam logic [7:0] CMD_ROW      = 8'h75;
    localparam logic [7:0] SHADOW_RESET = 8'hFF;
    localparam logic [2:0] SNAP_MARGIN  = 3'd4;

    localparam logic [5:0] RESET_ROW_BYTES = 6'd32;
    localparam logic [6:0] RESET_ROW_COUNT = 7'd32;

    typedef struct packed {
        logic full;
        logic probe_hit;
    } t_q_status;

endpackage

`default_nettype wire

[design/mdrdr_ram.sv]
// generic ram, one write port and two registered read ports
`timescale 1ns / 1ps
`default_nettype none

module mdrdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr_a,
    output logic      [WIDTH-1:0]  o_rdata_a,
    input  wire logic [ADDR_W-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

[design/mdrdr_front.sv]
// front end: shadow compare, span tracking, window and row decisions
`timescale 1ns / 1ps
`default_nettype none

module mdrdr_front import mdrdr_pkg::*; #(
    parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES,
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    localparam int COL_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1,
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int DEPTH = MAX_ROW_BYTES * MAX_ROWS,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [7:0]           i_pixel_byte,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]           i_cfg_data,
    output logic                      o_mem_we,
    output logic      [ADDR_W-1:0]    o_mem_waddr,
    output logic      [7:0]           o_mem_wdata,
    output logic      [ADDR_W-1:0]    o_mem_raddr,
    input  wire logic [7:0]           i_mem_rdata,
    input  wire t_q_status            i_q_status,
    output logic      [ROW_W-1:0]     o_probe_row,
    output logic                      o_q_push,
    output logic                      o_job_send_col,
    output logic                      o_job_send_row,
    output logic      [COL_W-1:0]     o_job_first,
    output logic      [COL_W-1:0]     o_job_last,
    output logic      [ROW_W-1:0]     o_job_row,
    output logic      [7:0]           o_job_rows_m1,
    input  wire logic                 i_back_busy,
    input  wire logic [ROW_W-1:0]     i_back_row
);

    localparam int KW = COL_W + 3;
    localparam int EXP_W = ROW_W + 1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CMP
    } t_state;

    t_state            r_state;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_span_first;
    logic [COL_W-1:0]  r_span_last;
    logic              r_row_changed;
    logic [COL_W-1:0]  r_win_first;
    logic [COL_W-1:0]  r_win_last;
    logic              r_win_valid;
    logic [EXP_W-1:0]  r_exp_row;
    logic              r_exp_valid;
    logic [7:0]        r_px;
    logic [5:0]        r_row_bytes;
    logic [6:0]        r_row_count;

    logic              in_acc;
    logic              row_hit;
    logic [ADDR_W-1:0] cur_addr;
    logic              changed;
    logic [COL_W-1:0]  n_first;
    logic [COL_W-1:0]  n_last;
    logic              n_changed;
    logic [6:0]        rb_eff;
    logic [8:0]        rc_eff;
    logic              row_end;
    logic              frame_end;
    logic [ROW_W-1:0]  n_row;
    logic              keep;
    logic              push;

    assign cur_addr = ADDR_W'(int'(r_row) * MAX_ROW_BYTES + int'(r_col));

    assign row_hit = i_q_status.probe_hit || (i_back_busy && (i_back_row == r_row));
    assign o_in_stall = !((r_state == S_IDLE) && !i_q_status.full && !row_hit);
    assign in_acc = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // effective register values
    always_comb begin
        if (r_row_bytes == 6'd0) begin
            rb_eff = 7'd1;
        end else if ({1'b0, r_row_bytes} > 7'(MAX_ROW_BYTES)) begin
            rb_eff = 7'(MAX_ROW_BYTES);
        end else begin
            rb_eff = {1'b0, r_row_bytes};
        end
        if (r_row_count == 7'd0) begin
            rc_eff = 9'd1;
        end else if ({2'b00, r_row_count} > 9'(MAX_ROWS)) begin
            rc_eff = 9'(MAX_ROWS);
        end else begin
            rc_eff = {2'b00, r_row_count};
        end
    end

    assign changed   = (i_mem_rdata != r_px);
    assign n_first   = (changed && !r_row_changed) ? r_col : r_span_first;
    assign n_last    = changed ? r_col : r_span_last;
    assign n_changed = r_row_changed | changed;
    assign row_end   = (7'(r_col) + 7'd1) >= rb_eff;
    assign frame_end = (9'(r_row) + 9'd1) >= rc_eff;
    assign n_row     = frame_end ? '0 : r_row + 1'b1;

    // new span strictly inside the old window, within the margin on each side
    assign keep = r_win_valid
               && (n_first > r_win_first)
               && (KW'(n_first) <= KW'(r_win_first) + KW'(SNAP_MARGIN))
               && (n_last < r_win_last)
               && (KW'(n_last) + KW'(SNAP_MARGIN) >= KW'(r_win_last));

    assign push = (r_state == S_CMP) && row_end && n_changed;

    assign o_q_push       = push;
    assign o_job_send_col = !keep;
    assign o_job_send_row = !(r_exp_valid && (r_exp_row == EXP_W'(r_row)));
    assign o_job_first    = keep ? r_win_first : n_first;
    assign o_job_last     = keep ? r_win_last : n_last;
    assign o_job_row      = r_row;
    assign o_job_rows_m1  = 8'(rc_eff - 9'd1);
    assign o_probe_row    = r_row;

    assign o_mem_we    = (r_state == S_CLEAR) || (r_state == S_CMP);
    assign o_mem_waddr = (r_state == S_CLEAR) ? r_clr_addr : cur_addr;
    assign o_mem_wdata = (r_state == S_CLEAR) ? SHADOW_RESET : r_px;
    assign o_mem_raddr = cur_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_col         <= '0;
            r_row         <= '0;
            r_span_first  <= '0;
            r_span_last   <= '0;
            r_row_changed <= 1'b0;
            r_win_first   <= '0;
            r_win_last    <= '0;
            r_win_valid   <= 1'b0;
            r_exp_row     <= '0;
            r_exp_valid   <= 1'b0;
            r_row_bytes   <= RESET_ROW_BYTES;
            r_row_count   <= RESET_ROW_COUNT;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_ROW_BYTES: r_row_bytes <= i_cfg_data[5:0];
                    REG_ROW_COUNT: r_row_count <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_px <= i_pixel_byte;
                        // frame start
                        if ((r_col == '0) && (r_row == '0)) begin
                            r_win_valid <= 1'b0;
                            r_exp_valid <= 1'b0;
                        end
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_IDLE;
                    if (row_end) begin
                        r_row_changed <= 1'b0;
                        r_span_first  <= '0;
                        r_span_last   <= '0;
                        r_col         <= '0;
                        r_row         <= n_row;
                        if (n_changed) begin
                            if (!keep) begin
                                r_win_first <= n_first;
                                r_win_last  <= n_last;
                                r_win_valid <= 1'b1;
                            end
                            r_exp_row   <= EXP_W'(r_row) + 1'b1;
                            r_exp_valid <= 1'b1;
                        end
                    end else begin
                        r_col         <= r_col + 1'b1;
                        r_span_first  <= n_first;
                        r_span_last   <= n_last;
                        r_row_changed <= n_changed;
                    end
                end
            endcase
        end
    end

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !i_q_status.full)
        else $error("row job pushed into a full queue");

    a_span_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP && row_end) |=> (!r_row_changed && r_col == '0))
        else $error("span tracker not cleared after row end");

endmodule

`default_nettype wire

[design/mdrdr_queue.sv]
// short queue of row jobs between front and back, with a row probe
`timescale 1ns / 1ps
`default_nettype none

module mdrdr_queue import mdrdr_pkg::*; #(
    parameter int COL_W = 5,
    parameter int ROW_W = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic             i_send_col,
    input  wire logic             i_send_row,
    input  wire logic [COL_W-1:0] i_first,
    input  wire logic [COL_W-1:0] i_last,
    input  wire logic [ROW_W-1:0] i_row,
    input  wire logic [7:0]       i_rows_m1,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic                  o_send_col,
    output logic                  o_send_row,
    output logic      [COL_W-1:0] o_first,
    output logic      [COL_W-1:0] o_last,
    output logic      [ROW_W-1:0] o_row,
    output logic      [7:0]       o_rows_m1,
    input  wire logic [ROW_W-1:0] i_probe_row,
    output t_q_status             o_status
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [QUEUE_DEPTH-1:0] r_vld;
    logic                   r_send_col [QUEUE_DEPTH];
    logic                   r_send_row [QUEUE_DEPTH];
    logic [COL_W-1:0]       r_first    [QUEUE_DEPTH];
    logic [COL_W-1:0]       r_last     [QUEUE_DEPTH];
    logic [ROW_W-1:0]       r_row      [QUEUE_DEPTH];
    logic [7:0]             r_rows_m1  [QUEUE_DEPTH];
    logic [PW-1:0]          r_wr;
    logic [PW-1:0]          r_rd;

    logic [QUEUE_DEPTH-1:0] hits;
    logic [QUEUE_DEPTH-1:0] n_vld;

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            hits[i] = r_vld[i] && (r_row[i] == i_probe_row);
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (i_pop) begin
            n_vld[r_rd] = 1'b0;
        end
        if (i_push) begin
            n_vld[r_wr] = 1'b1;
        end
    end

    assign o_status.full      = &r_vld;
    assign o_status.probe_hit = |hits;

    assign o_valid    = r_vld[r_rd];
    assign o_send_col = r_send_col[r_rd];
    assign o_send_row = r_send_row[r_rd];
    assign o_first    = r_first[r_rd];
    assign o_last     = r_last[r_rd];
    assign o_row      = r_row[r_rd];
    assign o_rows_m1  = r_rows_m1[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_wr  <= '0;
            r_rd  <= '0;
        end else begin
            r_vld <= n_vld;
            if (i_pop) begin
                r_rd <= (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push) begin
                r_send_col[r_wr] <= i_send_col;
                r_send_row[r_wr] <= i_send_row;
                r_first[r_wr]    <= i_first;
                r_last[r_wr]     <= i_last;
                r_row[r_wr]      <= i_row;
                r_rows_m1[r_wr]  <= i_rows_m1;
                r_wr <= (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
        end
    end

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_vld[r_wr])
        else $error("push overwrites a pending job");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_vld[r_rd])
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

[design/mdrdr_back.sv]
// back end: sends window and row commands, then the row's data from the shadow
`timescale 1ns / 1ps
`default_nettype none

module mdrdr_back import mdrdr_pkg::*; #(
    parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES,
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    localparam int COL_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1,
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int DEPTH = MAX_ROW_BYTES * MAX_ROWS,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire logic              i_send_col,
    input  wire logic              i_send_row,
    input  wire logic [COL_W-1:0]  i_first,
    input  wire logic [COL_W-1:0]  i_last,
    input  wire logic [ROW_W-1:0]  i_row,
    input  wire logic [7:0]        i_rows_m1,
    output logic                   o_pop,
    output logic      [ADDR_W-1:0] o_rd_addr,
    input  wire logic [7:0]        i_rd_data,
    output logic                   o_busy,
    output logic      [ROW_W-1:0]  o_busy_row,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [7:0]        o_out_byte,
    output logic                   o_is_command,
    output logic                   o_run_end
);

    localparam logic [1:0] LAST_K = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COL,
        S_ROW,
        S_DRD,
        S_DOUT
    } t_state;

    t_state           r_state;
    logic             r_job_send_row;
    logic [COL_W-1:0] r_job_first;
    logic [COL_W-1:0] r_job_last;
    logic [ROW_W-1:0] r_job_row;
    logic [7:0]       r_job_rows_m1;
    logic [1:0]       r_k;
    logic [COL_W-1:0] r_c;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_cmd;
    logic             r_out_end;

    logic             out_free;
    logic             out_load;
    logic [7:0]       col_byte;
    logic [7:0]       row_byte;

    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = out_free &&
                      ((r_state == S_COL) || (r_state == S_ROW) || (r_state == S_DOUT));
    assign o_pop    = (r_state == S_IDLE) && i_q_valid;
    assign o_busy   = (r_state != S_IDLE);
    assign o_busy_row = r_job_row;
    assign o_rd_addr  = ADDR_W'(int'(r_job_row) * MAX_ROW_BYTES + int'(r_c));

    always_comb begin
        case (r_k)
            2'd0:    col_byte = CMD_COLUMN;
            2'd1:    col_byte = 8'(r_job_first);
            default: col_byte = 8'(r_job_last);
        endcase
        case (r_k)
            2'd0:    row_byte = CMD_ROW;
            2'd1:    row_byte = 8'(r_job_row);
            default: row_byte = r_job_rows_m1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_job_send_row <= i_send_row;
                        r_job_first    <= i_first;
                        r_job_last     <= i_last;
                        r_job_row      <= i_row;
                        r_job_rows_m1  <= i_rows_m1;
                        r_k            <= '0;
                        r_c            <= i_first;
                        if (i_send_col) begin
                            r_state <= S_COL;
                        end else if (i_send_row) begin
                            r_state <= S_ROW;
                        end else begin
                            r_state <= S_DRD;
                        end
                    end
                end
                S_COL: begin
                    if (out_free) begin
                        r_out_byte  <= col_byte;
                        r_out_cmd   <= 1'b1;
                        r_out_end   <= 1'b0;
                        if (r_k == LAST_K) begin
                            r_k     <= '0;
                            r_state <= r_job_send_row ? S_ROW : S_DRD;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                S_ROW: begin
                    if (out_free) begin
                        r_out_byte  <= row_byte;
                        r_out_cmd   <= 1'b1;
                        r_out_end   <= 1'b0;
                        if (r_k == LAST_K) begin
                            r_k     <= '0;
                            r_state <= S_DRD;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                S_DRD: begin
                    r_state <= S_DOUT;
                end
                S_DOUT: begin
                    if (out_free) begin
                        r_out_byte  <= i_rd_data;
                        r_out_cmd   <= 1'b0;
                        r_out_end   <= (r_c == r_job_last);
                        if (r_c == r_job_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_c     <= r_c + 1'b1;
                            r_state <= S_DRD;
                        end
                    end
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_is_command = r_out_cmd;
    assign o_run_end    = r_out_end;

    a_end_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_end) |-> !r_out_cmd)
        else $error("run end flagged on a command byte");

    a_pop_starts_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state != S_IDLE))
        else $error("job popped but sequencer stayed idle");

endmodule

`default_nettype wire

[design/mono_dirty_row_display_refresh_core.sv]
// top level: dirty-row refresh of a one-bit display from a shadow frame
// input: each byte is a shadow read, then a compare and write back, before the next is taken
// a row end with changes queues a job
// output: command bytes one per cycle unless stalled, data bytes each after a shadow read
// after reset the shadow is filled with 0xff, one byte per cycle, over all
// MAX_ROW_BYTES*MAX_ROWS bytes (2048 by default) with input stalled; config taken
`timescale 1ns / 1ps
`default_nettype none

module mono_dirty_row_display_refresh_core import mdrdr_pkg::*; #(
    parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [7:0]           i_pixel_byte,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic      [7:0]           o_out_byte,
    output logic                      o_is_command,
    output logic                      o_run_end,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]           i_cfg_data
);

    localparam int COL_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int DEPTH = MAX_ROW_BYTES * MAX_ROWS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [ADDR_W-1:0] mem_raddr_a;
    logic [7:0]        mem_rdata_a;
    logic [ADDR_W-1:0] mem_raddr_b;
    logic [7:0]        mem_rdata_b;

    t_q_status         q_status;
    logic [ROW_W-1:0]  probe_row;
    logic              q_push;
    logic              q_pop;
    logic              in_send_col;
    logic              in_send_row;
    logic [COL_W-1:0]  in_first;
    logic [COL_W-1:0]  in_last;
    logic [ROW_W-1:0]  in_row;
    logic [7:0]        in_rows_m1;
    logic              q_valid;
    logic              q_send_col;
    logic              q_send_row;
    logic [COL_W-1:0]  q_first;
    logic [COL_W-1:0]  q_last;
    logic [ROW_W-1:0]  q_row;
    logic [7:0]        q_rows_m1;
    logic              back_busy;
    logic [ROW_W-1:0]  back_row;

    mdrdr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_shadow (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_raddr_a),
        .o_rdata_a (mem_rdata_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_b (mem_rdata_b)
    );

    mdrdr_front #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .MAX_ROWS      (MAX_ROWS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pixel_byte   (i_pixel_byte),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr),
        .o_mem_wdata    (mem_wdata),
        .o_mem_raddr    (mem_raddr_a),
        .i_mem_rdata    (mem_rdata_a),
        .i_q_status     (q_status),
        .o_probe_row    (probe_row),
        .o_q_push       (q_push),
        .o_job_send_col (in_send_col),
        .o_job_send_row (in_send_row),
        .o_job_first    (in_first),
        .o_job_last     (in_last),
        .o_job_row      (in_row),
        .o_job_rows_m1  (in_rows_m1),
        .i_back_busy    (back_busy),
        .i_back_row     (back_row)
    );

    mdrdr_queue #(
        .COL_W (COL_W),
        .ROW_W (ROW_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_send_col  (in_send_col),
        .i_send_row  (in_send_row),
        .i_first     (in_first),
        .i_last      (in_last),
        .i_row       (in_row),
        .i_rows_m1   (in_rows_m1),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_send_col  (q_send_col),
        .o_send_row  (q_send_row),
        .o_first     (q_first),
        .o_last      (q_last),
        .o_row       (q_row),
        .o_rows_m1   (q_rows_m1),
        .i_probe_row (probe_row),
        .o_status    (q_status)
    );

    mdrdr_back #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .MAX_ROWS      (MAX_ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_send_col   (q_send_col),
        .i_send_row   (q_send_row),
        .i_first      (q_first),
        .i_last       (q_last),
        .i_row        (q_row),
        .i_rows_m1    (q_rows_m1),
        .o_pop        (q_pop),
        .o_rd_addr    (mem_raddr_b),
        .i_rd_data    (mem_rdata_b),
        .o_busy       (back_busy),
        .o_busy_row   (back_row),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_is_command (o_is_command),
        .o_run_end    (o_run_end)
    );

endmodule

`default_nettype wire

[verif/mono_dirty_row_display_refresh_checker.sv]
// checker for the dirty-row display refresh core: shadow frame predictor and output compare
`timescale 1ns / 1ps

module mono_dirty_row_display_refresh_checker import mdrdr_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_stall,
    input  wire logic [7:0]           i_pixel_byte,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_stall,
    input  wire logic [7:0]           i_out_byte,
    input  wire logic                 i_is_command,
    input  wire logic                 i_run_end,
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]           i_cfg_data,
    output int                        o_mismatches,
    output int                        o_outstanding
);

    localparam int SHADOW_DEPTH = DEF_MAX_ROW_BYTES * DEF_MAX_ROWS;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] value;
        logic       command;
        logic       last;
    } ctrl_byte_t;

    ctrl_byte_t expected_q[$];
    ctrl_byte_t want;
    int         mismatches = 0;

    logic [7:0] shadow [0:SHADOW_DEPTH-1];
    logic [5:0] row_bytes_reg;
    logic [6:0] row_count_reg;
    logic [4:0] col;
    logic [5:0] row;
    logic [4:0] span_lo;
    logic [4:0] span_hi;
    logic       dirty;
    logic [4:0] win_lo;
    logic [4:0] win_hi;
    logic       win_ok;
    logic [6:0] next_row;
    logic       next_row_ok;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    function automatic void queue_byte(input logic [7:0] value, input logic command,
                                       input logic last);
        ctrl_byte_t entry;
        entry.value   = value;
        entry.command = command;
        entry.last    = last;
        expected_q.push_back(entry);
    endfunction

    function automatic void absorb_pixel(input logic [7:0] px);
        int rb;
        int rc;
        int addr;
        int lo;
        int hi;
        int wl;
        int wh;
        int margin;
        int c;
        bit keep;
        rb = (row_bytes_reg == 0) ? 1 :
             ((row_bytes_reg > DEF_MAX_ROW_BYTES) ? DEF_MAX_ROW_BYTES : int'(row_bytes_reg));
        rc = (row_count_reg == 0) ? 1 :
             ((row_count_reg > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(row_count_reg));
        // frame start drops both trackers
        if (col == 0 && row == 0) begin
            win_ok      = 1'b0;
            next_row_ok = 1'b0;
        end
        addr = int'(row) * DEF_MAX_ROW_BYTES + int'(col);
        if (shadow[addr] != px) begin
            if (!dirty) span_lo = col;
            span_hi = col;
            dirty   = 1'b1;
        end
        shadow[addr] = px;
        if (int'(col) + 1 < rb) begin
            col = col + 5'd1;
            return;
        end
        if (dirty) begin
            lo     = int'(span_lo);
            hi     = int'(span_hi);
            wl     = int'(win_lo);
            wh     = int'(win_hi);
            margin = int'(SNAP_MARGIN);
            keep   = win_ok && lo > wl && lo <= wl + margin && hi < wh && hi + margin >= wh;
            if (keep) begin
                lo = wl;
                hi = wh;
            end else begin
                queue_byte(CMD_COLUMN, 1'b1, 1'b0);
                queue_byte(8'(lo), 1'b1, 1'b0);
                queue_byte(8'(hi), 1'b1, 1'b0);
                win_lo = 5'(lo);
                win_hi = 5'(hi);
                win_ok = 1'b1;
            end
            if (!(next_row_ok && next_row == {1'b0, row})) begin
                queue_byte(CMD_ROW, 1'b1, 1'b0);
                queue_byte(8'(row), 1'b1, 1'b0);
                queue_byte(8'(rc - 1), 1'b1, 1'b0);
            end
            next_row    = 7'(int'(row) + 1);
            next_row_ok = 1'b1;
            for (c = lo; c <= hi && c < DEF_MAX_ROW_BYTES; c++) begin
                queue_byte(shadow[int'(row) * DEF_MAX_ROW_BYTES + c], 1'b0, c == hi);
            end
        end
        dirty   = 1'b0;
        span_lo = '0;
        span_hi = '0;
        col     = '0;
        if (int'(row) + 1 < rc) row = row + 6'd1;
        else row = '0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < SHADOW_DEPTH; a++) shadow[a] = SHADOW_RESET;
            row_bytes_reg = RESET_ROW_BYTES;
            row_count_reg = RESET_ROW_COUNT;
            col           = '0;
            row           = '0;
            span_lo       = '0;
            span_hi       = '0;
            dirty         = 1'b0;
            win_lo        = '0;
            win_hi        = '0;
            win_ok        = 1'b0;
            next_row      = '0;
            next_row_ok   = 1'b0;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_ROW_BYTES: row_bytes_reg = i_cfg_data[5:0];
                    REG_ROW_COUNT: row_count_reg = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("unexpected transfer: byte %02h cmd %0b end %0b",
                                 i_out_byte, i_is_command, i_run_end);
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    if (want.value !== i_out_byte || want.command !== i_is_command ||
                        want.last !== i_run_end) begin
                        if (mismatches < REPORT_LIMIT)
                            $display("mismatch: expected byte %02h cmd %0b end %0b, got byte %02h cmd %0b end %0b",
                                     want.value, want.command, want.last,
                                     i_out_byte, i_is_command, i_run_end);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) absorb_pixel(i_pixel_byte);
        end
        o_mismatches  <= mismatches;
        o_outstanding <= expected_q.size();
    end

endmodule

[verif/mono_dirty_row_display_refresh_core_test.sv]
// testbench top for the dirty-row display refresh core: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module mono_dirty_row_display_refresh_core_test;
    import mdrdr_pkg::*;

    localparam int ITEMS        = 250;
    localparam int STALL_LIMIT  = 8000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    typedef enum int {ROW_SAME, ROW_SPAN, ROW_NEST, ROW_NOISE} row_kind_e;

    logic                 clk;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic [7:0]           pixel_byte = '0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    logic [7:0]           out_byte;
    logic                 is_command;
    logic                 run_end;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [7:0]           cfg_data   = '0;

    int mismatches;
    int outstanding;

    // stimulus side view of the frame and the block's raster position
    logic [7:0] img [0:DEF_MAX_ROW_BYTES*DEF_MAX_ROWS-1];
    int         cur_col = 0;
    int         cur_row = 0;
    int         rb_eff  = RESET_ROW_BYTES;
    int         rc_eff  = RESET_ROW_COUNT;
    int         sent    = 0;
    bit         steady  = 1'b0;
    int         hold_asks  = 0;
    int         holds_done = 0;

    mono_dirty_row_display_refresh_core DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_pixel_byte (pixel_byte),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_out_byte   (out_byte),
        .o_is_command (is_command),
        .o_run_end    (run_end),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    mono_dirty_row_display_refresh_checker refresh_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_pixel_byte  (pixel_byte),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_byte    (out_byte),
        .i_is_command  (is_command),
        .i_run_end     (run_end),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int clamp_size(input int v, input int hi);
        return (v == 0) ? 1 : ((v > hi) ? hi : v);
    endfunction

    task automatic push_pixel(input logic [7:0] px);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        pixel_byte <= px;
        do @(posedge clk); while (in_stall);
        sent++;
        img[cur_row * DEF_MAX_ROW_BYTES + cur_col] = px;
        if (cur_col + 1 < rb_eff) begin
            cur_col++;
        end else begin
            cur_col = 0;
            cur_row = (cur_row + 1 < rc_eff) ? cur_row + 1 : 0;
        end
    endtask

    // finish the current row; span rows force a change at both span ends
    task automatic send_row(input row_kind_e kind, input int lo, input int hi);
        int c;
        logic [7:0] prev;
        logic [7:0] px;
        do begin
            c    = cur_col;
            prev = img[cur_row * DEF_MAX_ROW_BYTES + c];
            case (kind)
                ROW_SAME: begin
                    px = prev;
                end
                ROW_NOISE: begin
                    px = 8'($urandom);
                end
                default: begin
                    if (c == lo || c == hi)
                        px = prev ^ 8'($urandom_range(1, 255));
                    else if (c > lo && c < hi && $urandom_range(0, 1) == 1)
                        px = prev ^ 8'($urandom_range(1, 255));
                    else
                        px = prev;
                end
            endcase
            push_pixel(px);
        end while (cur_col != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_geometry(input logic [7:0] rb_data, input logic [7:0] rc_data,
                                input bit with_spare);
        write_reg(REG_ROW_BYTES, rb_data);
        write_reg(REG_ROW_COUNT, rc_data);
        if (with_spare)
            write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_A : REG_SPARE_B, 8'($urandom));
        cfg_valid <= 1'b0;
        rb_eff = clamp_size(int'(rb_data[5:0]), DEF_MAX_ROW_BYTES);
        rc_eff = clamp_size(int'(rc_data[6:0]), DEF_MAX_ROWS);
    endtask

    // stop sending and wait for every predicted byte, then let the block go quiet
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial begin : receiver
        int gap;
        forever begin
            if (hold_asks != holds_done) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int c;
        int v;
        int lo;
        int hi;
        int pick;
        int rows;
        int random_start;
        bit nest_ok;
        int nest_lo;
        int nest_hi;
        row_kind_e kind;
        logic [7:0] rb_data;
        logic [7:0] rc_data;

        nest_ok = 1'b0;
        nest_lo = 0;
        nest_hi = 0;
        for (c = 0; c < DEF_MAX_ROW_BYTES * DEF_MAX_ROWS; c++) img[c] = SHADOW_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset geometry, full-width row with the widest possible span
        for (c = 0; c < DEF_MAX_ROW_BYTES; c++) begin
            case (c)
                0:       push_pixel(8'h00);
                9:       push_pixel(8'h80);
                10:      push_pixel(8'h01);
                31:      push_pixel(8'h7F);
                default: push_pixel(SHADOW_RESET);
            endcase
        end
        settle();

        // narrow frame: auto-increment skip, frame start, window reuse, row jump
        set_geometry(8'h04, 8'h03, 1'b1);
        send_row(ROW_SPAN, 1, 2);
        send_row(ROW_SAME, 0, 0);
        send_row(ROW_SPAN, 0, 3);
        send_row(ROW_SAME, 0, 0);
        send_row(ROW_SPAN, 1, 2);
        settle();

        // zero registers behave as one byte by one row, upper data bits ignored
        set_geometry(8'hC0, 8'h80, 1'b0);
        push_pixel(8'h00);
        push_pixel(8'h00);
        push_pixel(8'hFF);
        settle();

        // receiver holds off while rows keep coming, so the input backs up
        set_geometry(8'h04, 8'h04, 1'b0);
        hold_asks++;
        steady = 1'b1;
        repeat (10) send_row(ROW_NOISE, 0, 0);
        steady = 1'b0;
        settle();

        random_start = sent;
        while (sent - random_start < ITEMS) begin
            case ($urandom_range(0, 9))
                0:       v = 0;
                1:       v = 63;
                2:       v = 32;
                3:       v = 1;
                default: v = $urandom_range(2, 8);
            endcase
            rb_data = {2'($urandom), 6'(v)};
            case ($urandom_range(0, 9))
                0:       v = 0;
                1:       v = 127;
                2:       v = 64;
                3:       v = 1;
                default: v = $urandom_range(2, 6);
            endcase
            rc_data = {1'($urandom), 7'(v)};
            set_geometry(rb_data, rc_data, $urandom_range(0, 3) == 0);
            steady = ($urandom_range(0, 3) == 0);
            rows   = (rb_eff >= 16) ? $urandom_range(1, 2) : $urandom_range(3, 12);
            repeat (rows) begin
                pick = $urandom_range(0, 19);
                kind = (pick < 4) ? ROW_SAME : (pick < 11) ? ROW_SPAN :
                       (pick < 17) ? ROW_NEST : ROW_NOISE;
                if (kind == ROW_NEST && nest_ok && nest_hi - nest_lo >= 2 && nest_hi < rb_eff) begin
                    lo = $urandom_range(nest_lo + 1,
                                        (nest_lo + 4 < nest_hi - 1) ? nest_lo + 4 : nest_hi - 1);
                    hi = $urandom_range((lo > nest_hi - 4) ? lo : nest_hi - 4, nest_hi - 1);
                end else begin
                    lo = $urandom_range(0, rb_eff - 1);
                    hi = $urandom_range(lo, rb_eff - 1);
                    if (kind != ROW_SAME && kind != ROW_NOISE) begin
                        nest_lo = lo;
                        nest_hi = hi;
                        nest_ok = 1'b1;
                    end
                end
                send_row(kind, lo, hi);
            end
            // sometimes stop mid-row so the next geometry lands inside a row
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, rb_eff)) push_pixel(8'($urandom));
            steady = 1'b0;
            settle();
        end

        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[files.f]
design/mdrdr_pkg.sv
design/mdrdr_ram.sv
design/mdrdr_front.sv
design/mdrdr_queue.sv
design/mdrdr_back.sv
design/mono_dirty_row_display_refresh_core.sv
verif/mono_dirty_row_display_refresh_checker.sv
verif/mono_dirty_row_display_refresh_core_test.sv
